/* sv/bsfp_pkg.sv */
package bsfp_pkg;

    // FIFO sizes
    localparam int TX_DEPTH = 16;
    localparam int RX_DEPTH = 16;
    localparam int TX_AW    = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
    localparam int RX_AW    = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int TX_LW    = $clog2(TX_DEPTH + 1);
    localparam int RX_LW    = $clog2(RX_DEPTH + 1);

    // Reported fill count width
    localparam int FILL_W   = 5;
    localparam int BYTE_W   = 8;
    localparam int ACT_W    = 3;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_WRITE  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_READ   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_LINE   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_CLR_TX = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CLR_RX = 3'd4;

    // Result flags and state snapshot decided when an item is taken
    typedef struct packed {
        logic              accepted;
        logic              rd_pop;
        logic              pop1;
        logic              pop2;
        logic              empty_on;
        logic              done_on;
        logic              busy;
        logic [FILL_W-1:0] tx_fill;
        logic [FILL_W-1:0] rx_fill;
    } result_plan_t;

    // Memory accesses for the item
    typedef struct packed {
        logic             tx_wr;
        logic [TX_AW-1:0] tx_wr_addr;
        logic             rx_wr;
        logic [RX_AW-1:0] rx_wr_addr;
        logic             rx_rd;
        logic [RX_AW-1:0] rx_rd_addr;
        logic [TX_AW-1:0] tx_addr1;
        logic [TX_AW-1:0] tx_addr2;
    } mem_plan_t;

    // Current levels
    typedef struct packed {
        logic [TX_LW-1:0] tx_level;
        logic [RX_LW-1:0] rx_level;
    } level_t;

    // Ring pointer advance with wrap
    function automatic logic [TX_AW-1:0] tx_inc(input logic [TX_AW-1:0] p);
        logic [TX_AW:0] s;
        s = {1'b0, p} + (TX_AW+1)'(1);
        return (s >= (TX_AW+1)'(TX_DEPTH)) ? '0 : s[TX_AW-1:0];
    endfunction

    function automatic logic [RX_AW-1:0] rx_inc(input logic [RX_AW-1:0] p);
        logic [RX_AW:0] s;
        s = {1'b0, p} + (RX_AW+1)'(1);
        return (s >= (RX_AW+1)'(RX_DEPTH)) ? '0 : s[RX_AW-1:0];
    endfunction

endpackage

/* sv/bsfp_ram.sv */
module bsfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/bsfp_state.sv */
module bsfp_state (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      take,
    input  logic [2:0]                action,
    input  logic                      rx_ready,
    input  logic                      tx_empty_flag,
    input  logic                      tx_done_flag,
    output bsfp_pkg::result_plan_t    res,
    output bsfp_pkg::mem_plan_t       mem,
    output bsfp_pkg::level_t          lvl
);
    import bsfp_pkg::*;

    logic [TX_AW-1:0] tx_head_reg, tx_head_next, tx_tail_reg, tx_tail_next;
    logic [RX_AW-1:0] rx_head_reg, rx_head_next, rx_tail_reg, rx_tail_next;
    logic [TX_LW-1:0] tx_level_reg, tx_level_next;
    logic [RX_LW-1:0] rx_level_reg, rx_level_next;
    logic             empty_on_reg, empty_on_next;
    logic             done_on_reg, done_on_next;
    logic             busy_reg, busy_next;

    // Pointer, level and enable update for one item
    always_comb
    begin
        logic [TX_AW-1:0]        tail_mid;
        logic [TX_LW-1:0]        lvl_mid;
        logic [TX_LW+FILL_W-1:0] tx_ext;
        logic [RX_LW+FILL_W-1:0] rx_ext;

        tx_head_next  = tx_head_reg;
        tx_tail_next  = tx_tail_reg;
        tx_level_next = tx_level_reg;
        rx_head_next  = rx_head_reg;
        rx_tail_next  = rx_tail_reg;
        rx_level_next = rx_level_reg;
        empty_on_next = empty_on_reg;
        done_on_next  = done_on_reg;
        busy_next     = busy_reg;
        tail_mid      = tx_tail_reg;
        lvl_mid       = tx_level_reg;
        res           = '0;
        mem           = '0;

        unique case (action)
            ACT_WRITE:
            begin
                if (tx_level_reg < TX_LW'(TX_DEPTH))
                begin
                    tx_head_next  = tx_inc(tx_head_reg);
                    tx_level_next = tx_level_reg + TX_LW'(1);
                    res.accepted  = 1'b1;
                    mem.tx_wr     = 1'b1;
                end
                empty_on_next = 1'b1;
            end
            ACT_READ:
            begin
                if (rx_level_reg != '0)
                begin
                    rx_tail_next  = rx_inc(rx_tail_reg);
                    rx_level_next = rx_level_reg - RX_LW'(1);
                    res.rd_pop    = 1'b1;
                    mem.rx_rd     = 1'b1;
                end
            end
            ACT_LINE:
            begin
                // receive side; a full FIFO drops its oldest byte
                if (rx_ready)
                begin
                    mem.rx_wr    = 1'b1;
                    rx_head_next = rx_inc(rx_head_reg);
                    if (rx_level_reg < RX_LW'(RX_DEPTH))
                    begin
                        rx_level_next = rx_level_reg + RX_LW'(1);
                    end
                    else
                    begin
                        rx_tail_next = rx_inc(rx_tail_reg);
                    end
                end
                // transmit-empty branch, enable as held at entry
                if (tx_empty_flag && empty_on_reg)
                begin
                    if (tx_level_reg == '0)
                    begin
                        empty_on_next = 1'b0;
                        done_on_next  = 1'b1;
                    end
                    else
                    begin
                        busy_next = 1'b1;
                        res.pop1  = 1'b1;
                        tail_mid  = tx_inc(tx_tail_reg);
                        lvl_mid   = tx_level_reg - TX_LW'(1);
                    end
                end
                tx_tail_next  = tail_mid;
                tx_level_next = lvl_mid;
                // transmit-complete branch
                if (tx_done_flag && done_on_reg)
                begin
                    if (lvl_mid == '0)
                    begin
                        done_on_next = 1'b0;
                        busy_next    = 1'b0;
                    end
                    else
                    begin
                        res.pop2      = 1'b1;
                        tx_tail_next  = tx_inc(tail_mid);
                        tx_level_next = lvl_mid - TX_LW'(1);
                    end
                end
            end
            ACT_CLR_TX:
            begin
                tx_head_next  = '0;
                tx_tail_next  = '0;
                tx_level_next = '0;
            end
            ACT_CLR_RX:
            begin
                rx_head_next  = '0;
                rx_tail_next  = '0;
                rx_level_next = '0;
            end
            default:
            begin
            end
        endcase

        mem.tx_wr_addr = tx_head_reg;
        mem.rx_wr_addr = rx_head_reg;
        mem.rx_rd_addr = rx_tail_reg;
        mem.tx_addr1   = tx_tail_reg;
        mem.tx_addr2   = tail_mid;

        // state after the step; fill counts masked to the field width
        tx_ext       = {FILL_W'(0), tx_level_next};
        rx_ext       = {FILL_W'(0), rx_level_next};
        res.tx_fill  = tx_ext[FILL_W-1:0];
        res.rx_fill  = rx_ext[FILL_W-1:0];
        res.empty_on = empty_on_next;
        res.done_on  = done_on_next;
        res.busy     = busy_next;
    end

    // Commit on each taken item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_head_reg  <= '0;
            tx_tail_reg  <= '0;
            tx_level_reg <= '0;
            rx_head_reg  <= '0;
            rx_tail_reg  <= '0;
            rx_level_reg <= '0;
            empty_on_reg <= 1'b0;
            done_on_reg  <= 1'b0;
            busy_reg     <= 1'b0;
        end
        else if (take)
        begin
            tx_head_reg  <= tx_head_next;
            tx_tail_reg  <= tx_tail_next;
            tx_level_reg <= tx_level_next;
            rx_head_reg  <= rx_head_next;
            rx_tail_reg  <= rx_tail_next;
            rx_level_reg <= rx_level_next;
            empty_on_reg <= empty_on_next;
            done_on_reg  <= done_on_next;
            busy_reg     <= busy_next;
        end
    end

    assign lvl.tx_level = tx_level_reg;
    assign lvl.rx_level = rx_level_reg;

endmodule

/* sv/buffered_serial_fifo_pair_unit.sv */
// Buffered serial FIFO pair: transmit and receive byte rings between a host
// and a serial line.
// Input channel (in_valid / in_stall) carries one item: an action code
// (host write, host read, line event, clear transmit, clear receive), a data
// byte and the three line flags. Output channel (out_valid / out_stall)
// returns exactly one result per item: write/read status, popped byte, the
// bytes handed to the line by the transmit-empty and transmit-complete
// branches, the interrupt enables, the busy flag and both fill counts.
// Each result passes through the fetch step S_RD1, then S_RD2 when a line
// event pops two transmit bytes, then S_OUT, which loads the output
// register. A new item is taken only once the sequencer is back in idle; it
// fetches bytes through the single registered read port of each ring RAM.
// Pointers, levels and counters are updated in the accept cycle; only the
// byte data comes back from RAM afterwards, so a write and a read to the
// same entry never fall in the same cycle.
// Reset clears pointers, levels, enables and busy flag; RAM contents are
// left undefined and never read before being written.
// While the receiver stalls a valid result, that result is held and the
// sequencer waits in its last step with in_stall high.
module buffered_serial_fifo_pair_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] action,
    input  logic [7:0] data_byte,
    input  logic       rx_ready,
    input  logic       tx_empty_flag,
    input  logic       tx_done_flag,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       accepted,
    output logic       read_valid,
    output logic [7:0] read_data,
    output logic       send_valid,
    output logic [7:0] send_data,
    output logic       send2_valid,
    output logic [7:0] send2_data,
    output logic       empty_irq_enabled,
    output logic       done_irq_enabled,
    output logic       sending,
    output logic [4:0] tx_fill,
    output logic [4:0] rx_fill
);
    import bsfp_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD1  = 2'd1;
    localparam logic [1:0] S_RD2  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic              take;
    logic              out_load;
    logic              out_valid_reg, out_valid_next;
    result_plan_t      res;
    mem_plan_t         mem;
    level_t            lvl;
    result_plan_t      pend_reg;
    logic [TX_AW-1:0]  addr2_reg;
    logic [BYTE_W-1:0] rdat_reg, s1_reg, s2_reg;
    logic              tx_rd_en;
    logic [TX_AW-1:0]  tx_rd_addr;
    logic [BYTE_W-1:0] tx_rd_data, rx_rd_data;

    assign in_stall = (state_reg != S_IDLE);
    assign take     = in_valid && !in_stall;
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);

    bsfp_state u_state (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .action        (action),
        .rx_ready      (rx_ready),
        .tx_empty_flag (tx_empty_flag),
        .tx_done_flag  (tx_done_flag),
        .res           (res),
        .mem           (mem),
        .lvl           (lvl)
    );

    // Transmit ring: first pop read at accept, second pop read in S_RD1
    assign tx_rd_en   = (take && res.pop1) || ((state_reg == S_RD1) && pend_reg.pop2);
    assign tx_rd_addr = (state_reg == S_RD1) ? addr2_reg : mem.tx_addr1;

    bsfp_ram #(.WIDTH(BYTE_W), .DEPTH(TX_DEPTH)) u_tx_ram (
        .clk     (clk),
        .wr_en   (take && mem.tx_wr),
        .wr_addr (mem.tx_wr_addr),
        .wr_data (data_byte),
        .rd_en   (tx_rd_en),
        .rd_addr (tx_rd_addr),
        .rd_data (tx_rd_data)
    );

    bsfp_ram #(.WIDTH(BYTE_W), .DEPTH(RX_DEPTH)) u_rx_ram (
        .clk     (clk),
        .wr_en   (take && mem.rx_wr),
        .wr_addr (mem.rx_wr_addr),
        .wr_data (data_byte),
        .rd_en   (take && mem.rx_rd),
        .rd_addr (mem.rx_rd_addr),
        .rd_data (rx_rd_data)
    );

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    state_next = S_RD1;
                end
            end
            S_RD1:
            begin
                state_next = pend_reg.pop2 ? S_RD2 : S_OUT;
            end
            S_RD2:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Item context and fetched bytes
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pend_reg  <= res;
            addr2_reg <= mem.tx_addr2;
        end
        if (state_reg == S_RD1)
        begin
            rdat_reg <= pend_reg.rd_pop ? rx_rd_data : '0;
            s1_reg   <= pend_reg.pop1 ? tx_rd_data : '0;
        end
        if (state_reg == S_RD2)
        begin
            s2_reg <= tx_rd_data;
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            accepted          <= pend_reg.accepted;
            read_valid        <= pend_reg.rd_pop;
            read_data         <= rdat_reg;
            send_valid        <= pend_reg.pop1;
            send_data         <= s1_reg;
            send2_valid       <= pend_reg.pop2;
            send2_data        <= pend_reg.pop2 ? s2_reg : '0;
            empty_irq_enabled <= pend_reg.empty_on;
            done_irq_enabled  <= pend_reg.done_on;
            sending           <= pend_reg.busy;
            tx_fill           <= pend_reg.tx_fill;
            rx_fill           <= pend_reg.rx_fill;
        end
    end

    assign out_valid = out_valid_reg;

    // Levels never exceed the ring sizes
    assert property (@(posedge clk) disable iff (!rst_n)
        lvl.tx_level <= TX_LW'(TX_DEPTH))
        else $error("transmit level above depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        lvl.rx_level <= RX_LW'(RX_DEPTH))
        else $error("receive level above depth");

    // A taken item starts its fetch step next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        take |=> (state_reg == S_RD1))
        else $error("sequencer missed taken item");

    // Host results and line sends never mix in one result, nor write and read status
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !((accepted || read_valid) && (send_valid || send2_valid))
                      && !(accepted && read_valid))
        else $error("mixed result kinds");

endmodule

/* sim/tb_buffered_serial_fifo_pair_unit.sv */
module tb_buffered_serial_fifo_pair_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import bsfp_pkg::*;

    // Spare action codes: the block reports its state and does nothing else
    localparam logic [ACT_W-1:0] ACT_SPARE_LO  = 3'd5;
    localparam logic [ACT_W-1:0] ACT_SPARE_MID = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE_HI  = 3'd7;

    localparam int RAND_ITEMS  = 480;
    localparam int CALM_ITEMS  = 60;
    localparam int MOOD_LEN    = 40;
    localparam int DRAIN_AT    = 250;
    localparam int CYCLE_LIMIT = 300000;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [BYTE_W-1:0] data;
        logic              rx_ready;
        logic              tx_empty_flag;
        logic              tx_done_flag;
    } serial_cmd_t;

    // Same bit order as the result ports
    typedef struct packed {
        logic              accepted;
        logic              read_valid;
        logic [BYTE_W-1:0] read_data;
        logic              send_valid;
        logic [BYTE_W-1:0] send_data;
        logic              send2_valid;
        logic [BYTE_W-1:0] send2_data;
        logic              empty_on;
        logic              done_on;
        logic              busy;
        logic [FILL_W-1:0] tx_fill;
        logic [FILL_W-1:0] rx_fill;
    } serial_result_t;

    typedef struct {
        serial_cmd_t    cmd;
        int             reps;
        bit             fixed;
        serial_result_t want;
    } stim_row_t;

    // DUT ports
    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [ACT_W-1:0]  action = '0;
    logic [BYTE_W-1:0] data_byte = '0;
    logic              rx_ready = 1'b0;
    logic              tx_empty_flag = 1'b0;
    logic              tx_done_flag = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              accepted;
    logic              read_valid;
    logic [7:0]        read_data;
    logic              send_valid;
    logic [7:0]        send_data;
    logic              send2_valid;
    logic [7:0]        send2_data;
    logic              empty_irq_enabled;
    logic              done_irq_enabled;
    logic              sending;
    logic [4:0]        tx_fill;
    logic [4:0]        rx_fill;

    // Shadow FIFO pair
    logic [BYTE_W-1:0] tx_ring [TX_DEPTH];
    logic [BYTE_W-1:0] rx_ring [RX_DEPTH];
    int                tx_wr_idx, tx_rd_idx, tx_held;
    int                rx_wr_idx, rx_rd_idx, rx_held;
    bit                empty_en, done_en, busy_now;

    serial_result_t    pending_results[$];
    stim_row_t         stim_table[$];

    // Run statistics
    int act_seen [8];
    int n_refused, n_overflow, n_double, n_checked, failures;
    int cycle_count;

    // Idling knobs
    int gap_pct;
    int stall_pct;
    int stall_left;
    bit calm;

    buffered_serial_fifo_pair_unit i_dut (.*);

    always #6 clk = ~clk;

    // Takes the oldest byte of the shadow transmit ring
    function automatic logic [BYTE_W-1:0] tx_take();
        logic [BYTE_W-1:0] b;
        b = tx_ring[tx_rd_idx];
        tx_rd_idx = (tx_rd_idx + 1) % TX_DEPTH;
        tx_held--;
        return b;
    endfunction

    // Applies one item to the shadow state and returns the expected result
    function automatic serial_result_t step_fifo_pair(input serial_cmd_t c);
        serial_result_t r;
        bit             e0;
        bit             d0;
        r  = '0;
        e0 = empty_en;
        d0 = done_en;
        act_seen[c.action]++;
        case (c.action)
            ACT_WRITE:
            begin
                if (tx_held < TX_DEPTH)
                begin
                    tx_ring[tx_wr_idx] = c.data;
                    tx_wr_idx = (tx_wr_idx + 1) % TX_DEPTH;
                    tx_held++;
                    r.accepted = 1'b1;
                end
                else
                begin
                    n_refused++;
                end
                // armed even when the byte is refused
                empty_en = 1'b1;
            end
            ACT_READ:
            begin
                if (rx_held != 0)
                begin
                    r.read_data  = rx_ring[rx_rd_idx];
                    r.read_valid = 1'b1;
                    rx_rd_idx = (rx_rd_idx + 1) % RX_DEPTH;
                    rx_held--;
                end
            end
            ACT_LINE:
            begin
                if (c.rx_ready)
                begin
                    rx_ring[rx_wr_idx] = c.data;
                    rx_wr_idx = (rx_wr_idx + 1) % RX_DEPTH;
                    // full ring drops its oldest byte
                    if (rx_held < RX_DEPTH)
                    begin
                        rx_held++;
                    end
                    else
                    begin
                        rx_rd_idx = (rx_rd_idx + 1) % RX_DEPTH;
                        n_overflow++;
                    end
                end
                // both transmit branches use the enables held at entry
                if (c.tx_empty_flag && e0)
                begin
                    if (tx_held == 0)
                    begin
                        empty_en = 1'b0;
                        done_en  = 1'b1;
                    end
                    else
                    begin
                        busy_now     = 1'b1;
                        r.send_data  = tx_take();
                        r.send_valid = 1'b1;
                    end
                end
                if (c.tx_done_flag && d0)
                begin
                    if (tx_held == 0)
                    begin
                        done_en  = 1'b0;
                        busy_now = 1'b0;
                    end
                    else
                    begin
                        r.send2_data  = tx_take();
                        r.send2_valid = 1'b1;
                    end
                end
                if (r.send_valid && r.send2_valid)
                begin
                    n_double++;
                end
            end
            ACT_CLR_TX:
            begin
                tx_wr_idx = 0;
                tx_rd_idx = 0;
                tx_held   = 0;
            end
            ACT_CLR_RX:
            begin
                rx_wr_idx = 0;
                rx_rd_idx = 0;
                rx_held   = 0;
            end
            default:
            begin
            end
        endcase
        r.empty_on = empty_en;
        r.done_on  = done_en;
        r.busy     = busy_now;
        r.tx_fill  = FILL_W'(tx_held);
        r.rx_fill  = FILL_W'(rx_held);
        return r;
    endfunction

    // Result with only status fields set, for rows typed in by hand
    function automatic serial_result_t status_only(input bit acc, input bit e, input bit d,
                                                   input bit b, input int txf, input int rxf);
        serial_result_t r;
        r          = '0;
        r.accepted = acc;
        r.empty_on = e;
        r.done_on  = d;
        r.busy     = b;
        r.tx_fill  = FILL_W'(txf);
        r.rx_fill  = FILL_W'(rxf);
        return r;
    endfunction

    function automatic string show_result(input serial_result_t r);
        return $sformatf({"acc=%0b rv=%0b rd=%02h sv=%0b sd=%02h s2v=%0b s2d=%02h ",
                          "en=%0b dn=%0b busy=%0b txf=%0d rxf=%0d"},
                         r.accepted, r.read_valid, r.read_data, r.send_valid, r.send_data,
                         r.send2_valid, r.send2_data, r.empty_on, r.done_on, r.busy,
                         r.tx_fill, r.rx_fill);
    endfunction

    task automatic add_row(input logic [ACT_W-1:0] act, input logic [BYTE_W-1:0] d,
                           input bit rxr, input bit txe, input bit txc, input int reps,
                           input bit fixed, input serial_result_t want);
        stim_row_t row;
        row.cmd   = '{act, d, rxr, txe, txc};
        row.reps  = reps;
        row.fixed = fixed;
        row.want  = want;
        stim_table.push_back(row);
    endtask

    // Drives one item, waits for it to be taken, then maybe idles
    task automatic send_cmd(input serial_cmd_t c, input bit fixed, input serial_result_t want);
        serial_result_t pred;
        in_valid      <= 1'b1;
        action        <= c.action;
        data_byte     <= c.data;
        rx_ready      <= c.rx_ready;
        tx_empty_flag <= c.tx_empty_flag;
        tx_done_flag  <= c.tx_done_flag;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        pred = step_fifo_pair(c);
        pending_results.push_back(fixed ? want : pred);
        if (!calm && $urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(12, 1)) @(posedge clk);
        end
    endtask

    // Holds off the sender until every outstanding result is back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic check_result(input serial_result_t got);
        serial_result_t want;
        string          bad;
        if (pending_results.size() == 0)
        begin
            failures++;
            if (failures <= 10)
            begin
                $display("%0t: result with nothing outstanding: %s",
                         $realtime, show_result(got));
            end
            return;
        end
        want = pending_results.pop_front();
        n_checked++;
        bad = "";
        if (got.accepted !== want.accepted)       bad = {bad, " accepted"};
        if (got.read_valid !== want.read_valid)   bad = {bad, " read_valid"};
        if (got.read_data !== want.read_data)     bad = {bad, " read_data"};
        if (got.send_valid !== want.send_valid)   bad = {bad, " send_valid"};
        if (got.send_data !== want.send_data)     bad = {bad, " send_data"};
        if (got.send2_valid !== want.send2_valid) bad = {bad, " send2_valid"};
        if (got.send2_data !== want.send2_data)   bad = {bad, " send2_data"};
        if (got.empty_on !== want.empty_on)       bad = {bad, " empty_irq_enabled"};
        if (got.done_on !== want.done_on)         bad = {bad, " done_irq_enabled"};
        if (got.busy !== want.busy)               bad = {bad, " sending"};
        if (got.tx_fill !== want.tx_fill)         bad = {bad, " tx_fill"};
        if (got.rx_fill !== want.rx_fill)         bad = {bad, " rx_fill"};
        if (bad != "")
        begin
            failures++;
            if (failures <= 10)
            begin
                $display("%0t: mismatch in%s", $realtime, bad);
                $display("    expected %s", show_result(want));
                $display("    actual   %s", show_result(got));
            end
        end
    endtask

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            check_result({accepted, read_valid, read_data, send_valid, send_data,
                          send2_valid, send2_data, empty_irq_enabled, done_irq_enabled,
                          sending, tx_fill, rx_fill});
        end
    end

    // Receiver stalls in bursts of random length
    always @(posedge clk)
    begin
        if (!rst_n || calm)
        begin
            out_stall  <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(99) < stall_pct)
        begin
            out_stall  <= 1'b1;
            stall_left = $urandom_range(11, 0);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        serial_cmd_t c;
        int          item_idx;
        int          n_real;
        int          pick;
        int          mood;
        int          w_write, w_read, w_line, w_ctx, w_crx;
        int          p_rx, p_tx;

        gap_pct   = 20;
        stall_pct = 15;
        calm      = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Idle state: nothing to read, spare codes and disabled line flags do nothing
        add_row(ACT_READ,      8'h00, 1'b0, 1'b0, 1'b0, 1, 1'b1, status_only(0, 0, 0, 0, 0, 0));
        add_row(ACT_SPARE_HI,  8'hFF, 1'b1, 1'b1, 1'b1, 1, 1'b1, status_only(0, 0, 0, 0, 0, 0));
        add_row(ACT_SPARE_LO,  8'h00, 1'b0, 1'b0, 1'b0, 1, 1'b1, status_only(0, 0, 0, 0, 0, 0));
        add_row(ACT_LINE,      8'hFF, 1'b0, 1'b1, 1'b1, 1, 1'b1, status_only(0, 0, 0, 0, 0, 0));
        // Writes arm the transmit-empty enable
        add_row(ACT_WRITE,     8'h00, 1'b0, 1'b0, 1'b0, 1, 1'b1, status_only(1, 1, 0, 0, 1, 0));
        add_row(ACT_WRITE,     8'hFF, 1'b1, 1'b1, 1'b1, 1, 1'b1, status_only(1, 1, 0, 0, 2, 0));
        // Feed the line, then empty FIFO swaps enables; new done enable waits a turn
        add_row(ACT_LINE,      8'hA5, 1'b1, 1'b1, 1'b1, 1, 1'b0, '0);
        add_row(ACT_LINE,      8'h5A, 1'b0, 1'b1, 1'b1, 1, 1'b0, '0);
        add_row(ACT_LINE,      8'h00, 1'b0, 1'b1, 1'b1, 1, 1'b0, '0);
        // Transmit-complete on empty FIFO drops busy
        add_row(ACT_LINE,      8'h00, 1'b0, 1'b1, 1'b1, 1, 1'b0, '0);
        add_row(ACT_READ,      8'h00, 1'b0, 1'b0, 1'b0, 1, 1'b0, '0);
        add_row(ACT_READ,      8'hFF, 1'b1, 1'b1, 1'b1, 1, 1'b0, '0);
        // Fill transmit FIFO and try one more
        add_row(ACT_WRITE,     8'h10, 1'b0, 1'b0, 1'b0, TX_DEPTH + 1, 1'b0, '0);
        // Drain it while the receive FIFO overflows
        add_row(ACT_LINE,      8'h80, 1'b1, 1'b1, 1'b0, RX_DEPTH + 1, 1'b0, '0);
        // Both enables on: one event hands two bytes to the line
        add_row(ACT_WRITE,     8'h3C, 1'b0, 1'b0, 1'b0, 1, 1'b0, '0);
        add_row(ACT_WRITE,     8'hC3, 1'b0, 1'b0, 1'b0, 1, 1'b0, '0);
        add_row(ACT_LINE,      8'h00, 1'b0, 1'b1, 1'b1, 1, 1'b0, '0);
        add_row(ACT_READ,      8'h00, 1'b0, 1'b0, 1'b0, 1, 1'b0, '0);
        // Clears touch only their own FIFO
        add_row(ACT_WRITE,     8'h55, 1'b0, 1'b0, 1'b0, 1, 1'b0, '0);
        add_row(ACT_CLR_TX,    8'hFF, 1'b1, 1'b1, 1'b1, 1, 1'b0, '0);
        add_row(ACT_CLR_RX,    8'h00, 1'b0, 1'b0, 1'b0, 1, 1'b0, '0);
        add_row(ACT_SPARE_MID, 8'hAA, 1'b0, 1'b1, 1'b0, 1, 1'b0, '0);

        foreach (stim_table[i])
        begin
            for (int k = 0; k < stim_table[i].reps; k++)
            begin
                c      = stim_table[i].cmd;
                c.data = c.data + 8'(k);
                send_cmd(c, stim_table[i].fixed, stim_table[i].want);
            end
        end
        drain_results();

        // Random part in moods: balanced, filling, draining
        item_idx = 0;
        n_real   = 0;
        mood     = 0;
        while (n_real < RAND_ITEMS)
        begin
            if (item_idx % MOOD_LEN == 0)
            begin
                mood = $urandom_range(2);
                case ($urandom_range(3))
                    0:       gap_pct = 0;
                    1:       gap_pct = 10;
                    2:       gap_pct = 30;
                    default: gap_pct = 60;
                endcase
                case ($urandom_range(3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 8;
                    2:       stall_pct = 20;
                    default: stall_pct = 40;
                endcase
            end
            if (n_real >= RAND_ITEMS - CALM_ITEMS)
            begin
                calm = 1'b1;
            end
            case (mood)
                0:
                begin
                    w_write = 30; w_read = 22; w_line = 38; w_ctx = 3; w_crx = 3;
                    p_rx = 50; p_tx = 50;
                end
                1:
                begin
                    w_write = 45; w_read = 8; w_line = 40; w_ctx = 1; w_crx = 1;
                    p_rx = 90; p_tx = 20;
                end
                default:
                begin
                    w_write = 15; w_read = 35; w_line = 44; w_ctx = 1; w_crx = 1;
                    p_rx = 20; p_tx = 80;
                end
            endcase
            pick = $urandom_range(99);
            if (pick < w_write)
                c.action = ACT_WRITE;
            else if (pick < w_write + w_read)
                c.action = ACT_READ;
            else if (pick < w_write + w_read + w_line)
                c.action = ACT_LINE;
            else if (pick < w_write + w_read + w_line + w_ctx)
                c.action = ACT_CLR_TX;
            else if (pick < w_write + w_read + w_line + w_ctx + w_crx)
                c.action = ACT_CLR_RX;
            else
                c.action = ACT_W'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO));
            c.data          = BYTE_W'($urandom_range(255));
            c.rx_ready      = ($urandom_range(99) < p_rx);
            c.tx_empty_flag = ($urandom_range(99) < p_tx);
            c.tx_done_flag  = ($urandom_range(99) < p_tx);
            send_cmd(c, 1'b0, '0);
            if (c.action <= ACT_CLR_RX)
            begin
                n_real++;
            end
            item_idx++;
            if (item_idx == DRAIN_AT)
            begin
                drain_results();
            end
        end

        // Wind down
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        failures += pending_results.size();

        $display("Ran %0d writes, %0d reads, %0d line events, %0d/%0d clears, %0d spare codes.",
                 act_seen[ACT_WRITE], act_seen[ACT_READ], act_seen[ACT_LINE],
                 act_seen[ACT_CLR_TX], act_seen[ACT_CLR_RX],
                 act_seen[ACT_SPARE_LO] + act_seen[ACT_SPARE_MID] + act_seen[ACT_SPARE_HI]);
        $display("Full-FIFO refusals %0d, receive overflows %0d, double sends %0d, %0d checked.",
                 n_refused, n_overflow, n_double, n_checked);
        if (failures == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* buffered_serial_fifo_pair_unit.f */
sv/bsfp_pkg.sv
sv/bsfp_ram.sv
sv/bsfp_state.sv
sv/buffered_serial_fifo_pair_unit.sv
sim/tb_buffered_serial_fifo_pair_unit.sv
